// ===== sv/lpf_pkg.sv =====
// shared types, constants and helpers for the three-axis low-pass unit
`timescale 1ns / 1ps

package lpf_pkg;

   // axis and field widths
   localparam int AXIS_COUNT = 3;
   localparam int AXIS_IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int RATE_W     = 32;
   localparam int CUTOFF_W   = 19;
   localparam int STEP_W     = 20;
   localparam int STATUS_W   = 2;

   // shared multiply-accumulate unit
   localparam int MAC_A_W    = 20;
   localparam int MAC_B_W    = 30;
   localparam int MAC_PROD_W = MAC_A_W + MAC_B_W;
   localparam int ACC_W      = 64;
   localparam int HI_SHIFT   = 20;

   // coefficient division
   localparam int ALPHA_BITS = 30;
   localparam int NUM_W      = 58;
   localparam int DEN_W      = 59;
   localparam int REM_W      = 60;
   localparam int DIV_CNT_W  = $clog2(ALPHA_BITS);

   // blend widths
   localparam int DIFF_W     = RATE_W + 1;
   localparam int P_W        = CUTOFF_W + STEP_W;

   // constants
   localparam logic [CUTOFF_W-1:0] CUTOFF_MAX     = 19'd500000;
   localparam logic [CUTOFF_W-1:0] TWO_PI_Q16     = 19'd411775;
   localparam logic [DEN_W-1:0]    NANO_SCALE_Q16 = 59'd65536000000000;
   localparam logic [ACC_W-1:0]    ROUND_INIT     = 64'd1 << (ALPHA_BITS - 1);

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_CUTOFF = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_STEP = 2'd2;

   // request command codes
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_RESET  = 1'b1;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_PROD,
      S_NUM_LO,
      S_NUM_HI,
      S_DIV_START,
      S_DIV_WAIT,
      S_DIFF,
      S_MUL_LO,
      S_MUL_HI,
      S_UPDATE,
      S_DONE
   } state_type;

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic en;
      logic clear;
      logic round;
      logic shift_hi;
   } mac_ctl_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // a cutoff register value that enables filtering
   function automatic logic cutoff_valid(input logic [CUTOFF_W-1:0] value);
      return (value != '0) && (value <= CUTOFF_MAX);
   endfunction

endpackage

// ===== sv/lpf_if.sv =====
// channel interfaces for request, response and control register write
`timescale 1ns / 1ps

interface lpf_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    cmd;
   logic signed [lpf_pkg::RATE_W-1:0]       rate_x;
   logic signed [lpf_pkg::RATE_W-1:0]       rate_y;
   logic signed [lpf_pkg::RATE_W-1:0]       rate_z;
   logic        [lpf_pkg::STEP_W-1:0]       step_us;

   modport source (output valid, cmd, rate_x, rate_y, rate_z, step_us, input ready);
   modport sink   (input valid, cmd, rate_x, rate_y, rate_z, step_us, output ready);
endinterface

interface lpf_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic        [lpf_pkg::STATUS_W-1:0]     status;
   logic signed [lpf_pkg::RATE_W-1:0]       filtered_x;
   logic signed [lpf_pkg::RATE_W-1:0]       filtered_y;
   logic signed [lpf_pkg::RATE_W-1:0]       filtered_z;

   modport source (output valid, status, filtered_x, filtered_y, filtered_z, input ready);
   modport sink   (input valid, status, filtered_x, filtered_y, filtered_z, output ready);
endinterface

interface lpf_csr_if;
   logic                                    valid;
   logic                                    ready;
   logic        [lpf_pkg::CUTOFF_W-1:0]     data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== sv/lpf_mac.sv =====
// shared multiply-accumulate unit used by every product of the filter
`timescale 1ns / 1ps

module lpf_mac (
   input  logic                          clock,
   input  lpf_pkg::mac_ctl_type          ctl,
   input  logic [lpf_pkg::MAC_A_W-1:0]   op_a,
   input  logic [lpf_pkg::MAC_B_W-1:0]   op_b,
   output logic [lpf_pkg::ACC_W-1:0]     acc
);

   logic [lpf_pkg::ACC_W-1:0]      acc_ff;
   logic [lpf_pkg::ACC_W-1:0]      acc_in;
   logic [lpf_pkg::MAC_PROD_W-1:0] prod;
   logic [lpf_pkg::ACC_W-1:0]      prod_ext;
   logic [lpf_pkg::ACC_W-1:0]      base;

   // one partial product, optionally weighted by the high split
   always_comb begin
      prod     = op_a * op_b;
      prod_ext = {{(lpf_pkg::ACC_W - lpf_pkg::MAC_PROD_W){1'b0}}, prod};
      if (ctl.shift_hi) begin
         prod_ext = prod_ext << lpf_pkg::HI_SHIFT;
      end
      if (ctl.clear) begin
         base = ctl.round ? lpf_pkg::ROUND_INIT : '0;
      end else begin
         base = acc_ff;
      end
      acc_in = ctl.en ? (base + prod_ext) : acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== sv/lpf_divider.sv =====
// restoring divider, one quotient bit per cycle, for the blend coefficient
`timescale 1ns / 1ps

module lpf_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [lpf_pkg::NUM_W-1:0]       num,
   output logic [lpf_pkg::ALPHA_BITS-1:0]  alpha,
   output lpf_pkg::div_stat_type           stat
);

   logic [lpf_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [lpf_pkg::DEN_W-1:0]      den_ff, den_in;
   logic [lpf_pkg::ALPHA_BITS-1:0] quo_ff, quo_in;
   logic [lpf_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [lpf_pkg::REM_W-1:0]      rem_shift;
   logic [lpf_pkg::REM_W-1:0]      den_ext;
   logic                           take;

   // load on start, then one compare and subtract per cycle
   always_comb begin
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      rem_shift = {rem_ff[lpf_pkg::REM_W-2:0], 1'b0};
      den_ext   = {1'b0, den_ff};
      take      = (rem_shift >= den_ext);
      if (start) begin
         rem_in  = {2'b00, num};
         den_in  = lpf_pkg::NANO_SCALE_Q16 + {1'b0, num};
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? (rem_shift - den_ext) : rem_shift;
         quo_in = {quo_ff[lpf_pkg::ALPHA_BITS-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lpf_pkg::DIV_CNT_W'(lpf_pkg::ALPHA_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign alpha     = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== sv/three_axis_first_order_lowpass_unit.sv =====
// top level: sequencer, axis state and response register of the low-pass unit
`timescale 1ns / 1ps

// Three-axis first-order low-pass for gyro rates (signed Q16.16).
// req_bus carries one transaction per sample: cmd (filter or reset state),
// rate_x/y/z and step_us. rsp_bus returns exactly one transaction per
// request: status and filtered_x/y/z. csr_bus writes the cutoff in mHz;
// a valid cutoff (1..500000) also clears the axis outputs and seed flag.
// Rejected, reset and seeding requests pass from the decide state to the
// done state, which loads the response register. A filtered sample runs
// one decide state, 3 multiply passes for the coefficient numerator, a
// divider start state, a wait while the one-bit-per-cycle divider forms 30
// quotient bits and flags done, 4 states per axis on the shared 20x30 MAC
// and the done state that loads the response register. A new request is
// taken only after the previous one has loaded its response; req ready is
// low while a request is in work.
// The response sits in its own output register, so the next request is
// taken while an earlier response waits; the block holds at the end of that
// next request until the receiver takes the pending response.
// Reset (synchronous, active high) clears the cutoff to unconfigured, the
// outputs to zero and the seed flag; no response is pending afterwards.
module three_axis_first_order_lowpass_unit (
   input  logic         clock,
   input  logic         reset,
   lpf_req_if.sink      req_bus,
   lpf_rsp_if.source    rsp_bus,
   lpf_csr_if.sink      csr_bus
);

   localparam int AXES = lpf_pkg::AXIS_COUNT;
   localparam int IW   = lpf_pkg::AXIS_IDX_W;
   localparam int RW   = lpf_pkg::RATE_W;
   localparam int DW   = lpf_pkg::DIFF_W;

   lpf_pkg::state_type state_ff, state_in;

   logic [lpf_pkg::CUTOFF_W-1:0] cutoff_ff, cutoff_in;
   logic                         seeded_ff, seeded_in;
   logic [RW-1:0]                y_ff [AXES];
   logic [RW-1:0]                y_in [AXES];

   // captured request
   logic                         cmd_ff, cmd_in;
   logic [RW-1:0]                rate_ff [AXES];
   logic [RW-1:0]                rate_in [AXES];
   logic [lpf_pkg::STEP_W-1:0]   step_ff, step_in;

   // per-request working registers
   logic [lpf_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         show_ff, show_in;
   logic [IW-1:0]                idx_ff, idx_in;
   logic [lpf_pkg::P_W-1:lpf_pkg::HI_SHIFT] p_hi_ff, p_hi_in;
   logic [DW-1:0]                mag_ff, mag_in;
   logic                         neg_ff, neg_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lpf_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [RW-1:0]                out_val_ff [AXES];
   logic [RW-1:0]                out_val_in [AXES];

   // shared unit connections
   lpf_pkg::mac_ctl_type          mac_ctl;
   logic [lpf_pkg::MAC_A_W-1:0]   mac_a;
   logic [lpf_pkg::MAC_B_W-1:0]   mac_b;
   logic [lpf_pkg::ACC_W-1:0]     acc;
   logic                          div_start;
   logic [lpf_pkg::ALPHA_BITS-1:0] alpha;
   lpf_pkg::div_stat_type         div_stat;

   // scratch
   logic [DW-1:0]                 diff;
   logic [DW-1:0]                 y_ext;
   logic [DW-1:0]                 delta;
   logic [DW-1:0]                 y_sum;
   logic                          req_take;
   logic                          csr_take;
   logic                          out_free;

   lpf_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (acc)
   );

   lpf_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc[lpf_pkg::NUM_W-1:0]),
      .alpha (alpha),
      .stat  (div_stat)
   );

   assign req_bus.ready = (state_ff == lpf_pkg::S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_take      = csr_bus.valid && csr_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // sequencer: next state, datapath control and register next values
   always_comb begin
      state_in      = state_ff;
      cutoff_in     = cutoff_ff;
      seeded_in     = seeded_ff;
      y_in          = y_ff;
      cmd_in        = cmd_ff;
      rate_in       = rate_ff;
      step_in       = step_ff;
      status_in     = status_ff;
      show_in       = show_ff;
      idx_in        = idx_ff;
      p_hi_in       = p_hi_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_status_in = out_status_ff;
      out_val_in    = out_val_ff;
      mac_ctl       = '0;
      mac_a         = '0;
      mac_b         = '0;
      div_start     = 1'b0;

      y_ext = {y_ff[idx_ff][RW-1], y_ff[idx_ff]};
      diff  = {rate_ff[idx_ff][RW-1], rate_ff[idx_ff]} - y_ext;
      delta = acc[lpf_pkg::ALPHA_BITS+DW-1:lpf_pkg::ALPHA_BITS];
      y_sum = neg_ff ? (y_ext - delta) : (y_ext + delta);

      // response taken by the receiver
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lpf_pkg::S_IDLE: begin
            if (req_take) begin
               cmd_in     = req_bus.cmd;
               rate_in[0] = req_bus.rate_x;
               rate_in[1] = req_bus.rate_y;
               rate_in[2] = req_bus.rate_z;
               step_in    = req_bus.step_us;
               state_in   = lpf_pkg::S_DECIDE;
            end
         end
         lpf_pkg::S_DECIDE: begin
            status_in = lpf_pkg::STATUS_OK;
            show_in   = 1'b0;
            idx_in    = '0;
            state_in  = lpf_pkg::S_DONE;
            if (!lpf_pkg::cutoff_valid(cutoff_ff)) begin
               status_in = lpf_pkg::STATUS_NO_CUTOFF;
            end else if (cmd_ff == lpf_pkg::CMD_RESET) begin
               for (int i = 0; i < AXES; i++) begin
                  y_in[i] = '0;
               end
               seeded_in = 1'b0;
            end else if (!seeded_ff) begin
               y_in      = rate_ff;
               seeded_in = 1'b1;
               show_in   = 1'b1;
            end else if (step_ff == '0) begin
               status_in = lpf_pkg::STATUS_ZERO_STEP;
            end else begin
               show_in  = 1'b1;
               state_in = lpf_pkg::S_PROD;
            end
         end
         // cutoff times step
         lpf_pkg::S_PROD: begin
            mac_ctl  = '{en: 1'b1, clear: 1'b1, round: 1'b0, shift_hi: 1'b0};
            mac_a    = step_ff;
            mac_b    = {{(lpf_pkg::MAC_B_W - lpf_pkg::CUTOFF_W){1'b0}}, cutoff_ff};
            state_in = lpf_pkg::S_NUM_LO;
         end
         // numerator, low split of the product
         lpf_pkg::S_NUM_LO: begin
            p_hi_in  = acc[lpf_pkg::P_W-1:lpf_pkg::HI_SHIFT];
            mac_ctl  = '{en: 1'b1, clear: 1'b1, round: 1'b0, shift_hi: 1'b0};
            mac_a    = acc[lpf_pkg::HI_SHIFT-1:0];
            mac_b    = {{(lpf_pkg::MAC_B_W - lpf_pkg::CUTOFF_W){1'b0}}, lpf_pkg::TWO_PI_Q16};
            state_in = lpf_pkg::S_NUM_HI;
         end
         // numerator, high split of the product
         lpf_pkg::S_NUM_HI: begin
            mac_ctl  = '{en: 1'b1, clear: 1'b0, round: 1'b0, shift_hi: 1'b1};
            mac_a    = {{(lpf_pkg::MAC_A_W - (lpf_pkg::P_W - lpf_pkg::HI_SHIFT)){1'b0}},
                        p_hi_ff};
            mac_b    = {{(lpf_pkg::MAC_B_W - lpf_pkg::CUTOFF_W){1'b0}}, lpf_pkg::TWO_PI_Q16};
            state_in = lpf_pkg::S_DIV_START;
         end
         lpf_pkg::S_DIV_START: begin
            div_start = 1'b1;
            state_in  = lpf_pkg::S_DIV_WAIT;
         end
         lpf_pkg::S_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = lpf_pkg::S_DIFF;
            end
         end
         // difference toward the input, as sign and magnitude
         lpf_pkg::S_DIFF: begin
            neg_in   = diff[DW-1];
            mag_in   = diff[DW-1] ? (~diff + 1'b1) : diff;
            state_in = lpf_pkg::S_MUL_LO;
         end
         lpf_pkg::S_MUL_LO: begin
            mac_ctl  = '{en: 1'b1, clear: 1'b1, round: 1'b1, shift_hi: 1'b0};
            mac_a    = mag_ff[lpf_pkg::HI_SHIFT-1:0];
            mac_b    = alpha;
            state_in = lpf_pkg::S_MUL_HI;
         end
         lpf_pkg::S_MUL_HI: begin
            mac_ctl  = '{en: 1'b1, clear: 1'b0, round: 1'b0, shift_hi: 1'b1};
            mac_a    = {{(lpf_pkg::MAC_A_W - (DW - lpf_pkg::HI_SHIFT)){1'b0}},
                        mag_ff[DW-1:lpf_pkg::HI_SHIFT]};
            mac_b    = alpha;
            state_in = lpf_pkg::S_UPDATE;
         end
         // rounded step toward the input, next axis
         lpf_pkg::S_UPDATE: begin
            y_in[idx_ff] = y_sum[RW-1:0];
            if (idx_ff == IW'(AXES - 1)) begin
               state_in = lpf_pkg::S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = lpf_pkg::S_DIFF;
            end
         end
         // load the response register once it is free
         lpf_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_status_in = status_ff;
               for (int i = 0; i < AXES; i++) begin
                  out_val_in[i] = show_ff ? y_ff[i] : '0;
               end
               state_in = lpf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lpf_pkg::S_IDLE;
         end
      endcase

      // cutoff write: the user must issue it only while no transaction is in work; the block does not enforce it
      if (csr_take) begin
         cutoff_in = csr_bus.data;
         if (lpf_pkg::cutoff_valid(csr_bus.data)) begin
            for (int i = 0; i < AXES; i++) begin
               y_in[i] = '0;
            end
            seeded_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpf_pkg::S_IDLE;
         cutoff_ff    <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            y_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cutoff_ff    <= cutoff_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
         y_ff         <= y_in;
      end
      cmd_ff        <= cmd_in;
      rate_ff       <= rate_in;
      step_ff       <= step_in;
      status_ff     <= status_in;
      show_ff       <= show_in;
      idx_ff        <= idx_in;
      p_hi_ff       <= p_hi_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      out_status_ff <= out_status_in;
      out_val_ff    <= out_val_in;
   end

   // response channel
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = out_status_ff;
   assign rsp_bus.filtered_x = out_val_ff[0];
   assign rsp_bus.filtered_y = out_val_ff[1];
   assign rsp_bus.filtered_z = out_val_ff[2];

endmodule

// ===== sv/lpf_checker.sv =====
// port-level assertions for the three-axis low-pass unit, bound to the top level
`timescale 1ns / 1ps

module lpf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [lpf_pkg::STATUS_W-1:0]      rsp_status,
   input logic [lpf_pkg::RATE_W-1:0]        rsp_filtered_x,
   input logic [lpf_pkg::RATE_W-1:0]        rsp_filtered_y,
   input logic [lpf_pkg::RATE_W-1:0]        rsp_filtered_z
);

   // a stalled response transaction holds its valid and payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_filtered_x) && $stable(rsp_filtered_y) && $stable(rsp_filtered_z))
   else $error("response changed while stalled");

   // request intake closes for the transaction just taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
   else $error("request ready stayed high after a transaction");

   // only the defined status codes are returned
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == lpf_pkg::STATUS_OK)
         || (rsp_status == lpf_pkg::STATUS_NO_CUTOFF)
         || (rsp_status == lpf_pkg::STATUS_ZERO_STEP))
   else $error("undefined response status");

   // a rejected sample reports all filtered fields as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != lpf_pkg::STATUS_OK)
         |-> (rsp_filtered_x == '0) && (rsp_filtered_y == '0) && (rsp_filtered_z == '0))
   else $error("rejected sample returned nonzero outputs");

endmodule

bind three_axis_first_order_lowpass_unit lpf_checker u_lpf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_filtered_x (rsp_bus.filtered_x),
   .rsp_filtered_y (rsp_bus.filtered_y),
   .rsp_filtered_z (rsp_bus.filtered_z)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for the three-axis first-order low-pass unit
`timescale 1ns / 1ps

module tb_top;

   // run limits and fixed-point constants of the filter coefficient
   localparam int                CYCLE_LIMIT   = 1000000;
   localparam int                ITEMS_PER_SET = 200;
   localparam int                SET_COUNT     = 9;
   localparam longint unsigned   TWO_PI_FIXED  = 64'd411775;
   localparam longint unsigned   NS_SCALE      = 64'd1000000000 << 16;
   localparam int                COEFF_BITS    = 30;
   localparam logic [lpf_pkg::CUTOFF_W-1:0] CUTOFF_TOP = 19'd500000;

   // one expected response transaction
   typedef struct packed {
      logic [lpf_pkg::STATUS_W-1:0] status;
      logic [lpf_pkg::RATE_W-1:0]   fx;
      logic [lpf_pkg::RATE_W-1:0]   fy;
      logic [lpf_pkg::RATE_W-1:0]   fz;
   } lpf_result_type;

   // tracks cutoff, axis outputs and seed flag; holds the expected responses
   class lowpass_tracker;
      logic [lpf_pkg::CUTOFF_W-1:0] cutoff;
      logic [lpf_pkg::RATE_W-1:0]   axis_out [lpf_pkg::AXIS_COUNT];
      bit                           seeded;
      lpf_result_type               expected_results [$];
      int                           mismatches;

      function new();
         cutoff     = '0;
         mismatches = 0;
         clear_filter();
      endfunction

      function void clear_filter();
         for (int i = 0; i < lpf_pkg::AXIS_COUNT; i++) axis_out[i] = '0;
         seeded = 1'b0;
      endfunction

      function bit cutoff_ok();
         return (cutoff != '0) && (cutoff <= CUTOFF_TOP);
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void write_cutoff(logic [lpf_pkg::CUTOFF_W-1:0] value);
         cutoff = value;
         if (cutoff_ok()) clear_filter();
      endfunction

      // alpha in Q0.30 by restoring division, one quotient bit per step
      function longint unsigned coeff(logic [lpf_pkg::STEP_W-1:0] step);
         longint unsigned num;
         longint unsigned den;
         longint unsigned rem;
         longint unsigned q;
         num = 64'(cutoff) * 64'(step) * TWO_PI_FIXED;
         den = NS_SCALE + num;
         rem = num;
         q   = 0;
         for (int i = 0; i < COEFF_BITS; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
               rem = rem - den;
               q   = q | 64'd1;
            end
         end
         return q;
      endfunction

      // move y toward x by alpha, rounding half away from zero
      function logic [lpf_pkg::RATE_W-1:0] blend(logic [lpf_pkg::RATE_W-1:0] y_bits,
                                                 logic [lpf_pkg::RATE_W-1:0] x_bits,
                                                 longint unsigned alpha);
         longint          y;
         longint          x;
         longint          d;
         longint          r;
         longint unsigned mag;
         longint unsigned delta;
         y     = $signed(y_bits);
         x     = $signed(x_bits);
         d     = x - y;
         mag   = (d < 0) ? 64'(-d) : 64'(d);
         delta = (mag * alpha + (64'd1 << (COEFF_BITS - 1))) >> COEFF_BITS;
         r     = (d < 0) ? (y - longint'(delta)) : (y + longint'(delta));
         return r[lpf_pkg::RATE_W-1:0];
      endfunction

      // accepted request: update state and queue the expected response
      function void take_sample(logic c, logic [lpf_pkg::RATE_W-1:0] rx,
                                logic [lpf_pkg::RATE_W-1:0] ry,
                                logic [lpf_pkg::RATE_W-1:0] rz,
                                logic [lpf_pkg::STEP_W-1:0] step);
         lpf_result_type             e;
         logic [lpf_pkg::RATE_W-1:0] rates [lpf_pkg::AXIS_COUNT];
         longint unsigned            alpha;
         bit                         show;
         rates    = '{rx, ry, rz};
         e.status = lpf_pkg::STATUS_OK;
         show     = 1'b0;
         if (!cutoff_ok()) begin
            e.status = lpf_pkg::STATUS_NO_CUTOFF;
         end else if (c == lpf_pkg::CMD_RESET) begin
            clear_filter();
         end else if (!seeded) begin
            for (int i = 0; i < lpf_pkg::AXIS_COUNT; i++) axis_out[i] = rates[i];
            seeded = 1'b1;
            show   = 1'b1;
         end else if (step == '0) begin
            e.status = lpf_pkg::STATUS_ZERO_STEP;
         end else begin
            alpha = coeff(step);
            for (int i = 0; i < lpf_pkg::AXIS_COUNT; i++) begin
               axis_out[i] = blend(axis_out[i], rates[i], alpha);
            end
            show = 1'b1;
         end
         e.fx = show ? axis_out[0] : '0;
         e.fy = show ? axis_out[1] : '0;
         e.fz = show ? axis_out[2] : '0;
         expected_results.push_back(e);
      endfunction

      function void flag(string msg);
         if (mismatches < 10) $display("%s", msg);
         mismatches++;
      endfunction

      // accepted response: compare against the oldest expectation
      function void check_output(lpf_result_type got);
         lpf_result_type e;
         if (expected_results.size() == 0) begin
            flag($sformatf("unexpected response: status %0d x %0d y %0d z %0d",
                           got.status, $signed(got.fx), $signed(got.fy), $signed(got.fz)));
            return;
         end
         e = expected_results.pop_front();
         if (got.status !== e.status || got.fx !== e.fx || got.fy !== e.fy
             || got.fz !== e.fz) begin
            flag($sformatf({"mismatch: exp status %0d x %0d y %0d z %0d,",
                            " got status %0d x %0d y %0d z %0d"},
                           e.status, $signed(e.fx), $signed(e.fy), $signed(e.fz),
                           got.status, $signed(got.fx), $signed(got.fy), $signed(got.fz)));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   int   send_idle_pct;
   int   rsp_idle_pct;

   lowpass_tracker tracker = new();

   lpf_req_if req_bus ();
   lpf_rsp_if rsp_bus ();
   lpf_csr_if csr_bus ();

   three_axis_first_order_lowpass_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** three_axis_first_order_lowpass_unit: FAILED **");
         $finish;
      end
   end

   // receiver stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // monitors on each transaction
   always @(posedge clock) begin
      if (!reset && csr_bus.valid && csr_bus.ready) tracker.write_cutoff(csr_bus.data);
      if (!reset && req_bus.valid && req_bus.ready) begin
         tracker.take_sample(req_bus.cmd, req_bus.rate_x, req_bus.rate_y, req_bus.rate_z,
                             req_bus.step_us);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         tracker.check_output('{rsp_bus.status, rsp_bus.filtered_x, rsp_bus.filtered_y,
                                rsp_bus.filtered_z});
      end
   end

   // one request transaction, with random idle cycles ahead of it
   task automatic send_req(input logic c, input logic [lpf_pkg::RATE_W-1:0] rx,
                           input logic [lpf_pkg::RATE_W-1:0] ry,
                           input logic [lpf_pkg::RATE_W-1:0] rz,
                           input logic [lpf_pkg::STEP_W-1:0] step);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.cmd     <= c;
      req_bus.rate_x  <= rx;
      req_bus.rate_y  <= ry;
      req_bus.rate_z  <= rz;
      req_bus.step_us <= step;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // hold off requests until every response has come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cutoff(input logic [lpf_pkg::CUTOFF_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // rate mix: extremes, full-range values and small gyro-like values
   function automatic logic [lpf_pkg::RATE_W-1:0] random_rate();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) begin
         case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
         endcase
      end else if (roll < 4) begin
         return $urandom;
      end
      return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
   endfunction

   task automatic send_random();
      logic                       c;
      logic [lpf_pkg::STEP_W-1:0] step;
      int                         roll;
      c    = ($urandom_range(99) < 3) ? lpf_pkg::CMD_RESET : lpf_pkg::CMD_FILTER;
      roll = $urandom_range(99);
      if (roll < 5)       step = '0;
      else if (roll < 10) step = '1;
      else if (roll < 25) step = lpf_pkg::STEP_W'($urandom);
      else                step = lpf_pkg::STEP_W'($urandom_range(1, 2000));
      send_req(c, random_rate(), random_rate(), random_rate(), step);
   endtask

   // directed sequence: register extremes and every special case
   task automatic run_directed();
      // unconfigured cutoff after reset, both commands
      send_req(lpf_pkg::CMD_FILTER, 32'd1, 32'd2, 32'd3, 20'd100);
      send_req(lpf_pkg::CMD_RESET, 32'd0, 32'd0, 32'd0, 20'd0);
      wait_idle();
      write_cutoff(19'd1000);
      // zero step before seeding seeds, zero step after seeding is rejected
      send_req(lpf_pkg::CMD_FILTER, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 20'd0);
      send_req(lpf_pkg::CMD_FILTER, 32'd5, 32'd6, 32'd7, 20'd0);
      // full-swing difference with the widest step, then the narrowest
      send_req(lpf_pkg::CMD_FILTER, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 20'hF_FFFF);
      send_req(lpf_pkg::CMD_FILTER, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'd1);
      // reset command, seeded and unseeded
      send_req(lpf_pkg::CMD_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hF_FFFF);
      send_req(lpf_pkg::CMD_RESET, 32'd0, 32'd0, 32'd0, 20'd10);
      send_req(lpf_pkg::CMD_FILTER, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 20'hF_FFFF);
      send_req(lpf_pkg::CMD_FILTER, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_0001, 20'd1000);
      wait_idle();
      write_cutoff(CUTOFF_TOP);
      send_req(lpf_pkg::CMD_FILTER, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'd500);
      send_req(lpf_pkg::CMD_FILTER, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 20'hF_FFFF);
      send_req(lpf_pkg::CMD_FILTER, 32'h1234_5678, 32'hEDCB_A988, 32'd3, 20'd1);
      wait_idle();
      write_cutoff(19'd1);
      send_req(lpf_pkg::CMD_FILTER, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 20'd77);
      send_req(lpf_pkg::CMD_FILTER, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 20'd1);
      send_req(lpf_pkg::CMD_FILTER, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 20'hF_FFFF);
      wait_idle();
      // cutoff above the valid range: every command is rejected
      write_cutoff(19'd500001);
      send_req(lpf_pkg::CMD_FILTER, 32'd9, 32'd9, 32'd9, 20'd100);
      send_req(lpf_pkg::CMD_RESET, 32'd0, 32'd0, 32'd0, 20'd100);
      send_req(lpf_pkg::CMD_FILTER, 32'd9, 32'd9, 32'd9, 20'd0);
      wait_idle();
      write_cutoff('1);
      send_req(lpf_pkg::CMD_FILTER, 32'd4, 32'd4, 32'd4, 20'd4);
      wait_idle();
      write_cutoff('0);
      send_req(lpf_pkg::CMD_FILTER, 32'd4, 32'd4, 32'd4, 20'd4);
      wait_idle();
   endtask

   // stimulus and end of run
   initial begin
      reset           = 1'b1;
      cycle_count     = 0;
      send_idle_pct   = 0;
      rsp_idle_pct    = 0;
      req_bus.valid   = 1'b0;
      req_bus.cmd     = lpf_pkg::CMD_FILTER;
      req_bus.rate_x  = '0;
      req_bus.rate_y  = '0;
      req_bus.rate_z  = '0;
      req_bus.step_us = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = '0;
      rsp_bus.ready   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // random sets: idle mix changes every third set, cutoff every set
      for (int set_idx = 0; set_idx < SET_COUNT; set_idx++) begin
         if (set_idx < 3) begin
            send_idle_pct = 30;
            rsp_idle_pct  = 85;
         end else if (set_idx < 6) begin
            send_idle_pct = 85;
            rsp_idle_pct  = 30;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         wait_idle();
         case (set_idx)
            0:       write_cutoff(CUTOFF_TOP);
            3:       write_cutoff(19'd1);
            6:       write_cutoff(19'd250);
            default: write_cutoff(lpf_pkg::CUTOFF_W'($urandom_range(1, 500000)));
         endcase
         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            // mid-set pause until all responses are back
            if (n == ITEMS_PER_SET / 2) wait_idle();
            send_random();
         end
      end

      wait_idle();
      repeat (64) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("** three_axis_first_order_lowpass_unit: PASSED **");
      end else begin
         $display("** three_axis_first_order_lowpass_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/lpf_pkg.sv
sv/lpf_if.sv
sv/lpf_mac.sv
sv/lpf_divider.sv
sv/three_axis_first_order_lowpass_unit.sv
sv/lpf_checker.sv
tb/tb_top.sv
